// ===== design/html_whitespace_minifier_macros.svh =====
// Assertion macros shared by the minifier RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef HTML_WHITESPACE_MINIFIER_MACROS_SVH
`define HTML_WHITESPACE_MINIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HWM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define HWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/hwm_pkg.sv =====
// Shared types, codes and character tables for the HTML whitespace minifier.
// No dependencies; used by the controller, datapath and top level.
package hwm_pkg;

	localparam int LOOKAHEAD_DEPTH = 32;
	localparam int RAM_AW          = $clog2(LOOKAHEAD_DEPTH);
	localparam int RAM_DEPTH       = 2 ** RAM_AW;
	localparam int CNT_W           = $clog2(LOOKAHEAD_DEPTH + 1);

	typedef logic [RAM_AW-1:0] ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// parse modes
	localparam logic [1:0] MODE_NORMAL   = 2'd0;
	localparam logic [1:0] MODE_VERBATIM = 2'd1;
	localparam logic [1:0] MODE_COMMENT  = 2'd2;

	// raw-content tag ids
	localparam logic [1:0] TAG_PRE      = 2'd0;
	localparam logic [1:0] TAG_SCRIPT   = 2'd1;
	localparam logic [1:0] TAG_STYLE    = 2'd2;
	localparam logic [1:0] TAG_TEXTAREA = 2'd3;

	// window recognizer phases
	localparam logic [2:0] PH_LT    = 3'd0;
	localparam logic [2:0] PH_BANG1 = 3'd1;
	localparam logic [2:0] PH_BANG2 = 3'd2;
	localparam logic [2:0] PH_WS    = 3'd3;
	localparam logic [2:0] PH_NAME  = 3'd4;
	localparam logic [2:0] PH_GT    = 3'd5;

	// window decisions
	localparam logic [2:0] DEC_PEND    = 3'd0;
	localparam logic [2:0] DEC_PLAIN   = 3'd1;
	localparam logic [2:0] DEC_COMMENT = 3'd2;
	localparam logic [2:0] DEC_OPEN    = 3'd3;
	localparam logic [2:0] DEC_CLOSE   = 3'd4;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic accept;
		logic feed;
		logic from_ram;
		logic rd_issue;
		logic fin_dec;
		logic finalize;
	} dp_cmd_t;

	typedef struct packed {
		logic room;
		logic out_free;
		logic end_doc;
		logic full_next;
		logic more_next;
		logic open_next;
	} dp_sts_t;

	function automatic logic is_ws(input logic [7:0] b);
		return b inside {8'h20, [8'h09:8'h0D]};
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		return b inside {CH_GT, CH_SPACE, 8'h09, 8'h0A, 8'h0D, CH_SLASH};
	endfunction

	function automatic logic [7:0] low_case(input logic [7:0] b);
		return (b inside {[8'h41:8'h5A]}) ? (b + 8'h20) : b;
	endfunction

	function automatic logic [3:0] tag_len(input logic [1:0] t);
		logic [3:0] n;
		case (t)
			TAG_PRE:      n = 4'd3;
			TAG_SCRIPT:   n = 4'd6;
			TAG_STYLE:    n = 4'd5;
			TAG_TEXTAREA: n = 4'd8;
			default:      n = 4'd3;
		endcase
		return n;
	endfunction

	// names left-aligned, padded with spaces that are never compared
	function automatic logic [7:0] tag_char(input logic [1:0] t, input logic [2:0] k);
		logic [63:0] s;
		case (t)
			TAG_PRE:      s = "pre     ";
			TAG_SCRIPT:   s = "script  ";
			TAG_STYLE:    s = "style   ";
			TAG_TEXTAREA: s = "textarea";
			default:      s = "pre     ";
		endcase
		return s[8*(3'd7 - k) +: 8];
	endfunction

endpackage

// ===== design/html_whitespace_minifier.sv =====
// Top level of the streaming HTML whitespace minifier.
// Depends on hwm_pkg, hwm_ctrl, hwm_datapath (and hwm_ram below it).
//
//  channel  | dir | tdata           | tuser (bit 0 up)             | tlast
//  s_axis   | in  | data_byte[7:0]  | -                            | end_of_doc
//  m_axis   | out | out_byte[7:0]   | byte_valid, window_overflow  | out_last
//
// A plain byte is accepted and stored, then fed through the parser. Each
// byte replayed from the lookahead RAM after a tag decision takes a
// registered RAM read, then a feed; a forced decision (window full or end
// of document) and the end flush are extra steps. The parser stalls while
// the output register is full and not taken, save into a free end hold slot.
// Reset (arst_n low) returns the parser to normal mode with an empty window;
// the RAM contents are not cleared and need no clearing pass.
module html_whitespace_minifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] window_overflow
	output logic       m_axis_tlast
);
	import hwm_pkg::*;

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic       bvalid, ovf;

	// controller: decides which datapath action runs each cycle
	hwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: stream RAM, window recognizer, parse state, output register
	hwm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_byte   (m_axis_tdata),
		.out_bvalid (bvalid),
		.out_last   (m_axis_tlast),
		.out_ovf    (ovf)
	);

	assign m_axis_tuser = {ovf, bvalid};
endmodule

// ===== design/hwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/hwm_ctrl.sv =====
// Sequencer for the minifier: accept, feed, replay reads, forced decisions, end flush.
// Depends on hwm_pkg and the assertion macro header.
`include "html_whitespace_minifier_macros.svh"
module hwm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hwm_pkg::dp_sts_t sts,
	output hwm_pkg::dp_cmd_t cmd
);
	import hwm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FEED  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;

	logic [2:0] state_q, state_d;
	logic       from_ram_q, from_ram_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.feed     = (state_q == S_FEED) && sts.room;
		cmd.from_ram = from_ram_q;
		cmd.rd_issue = (state_q == S_READ);
		cmd.fin_dec  = (state_q == S_FIN) && sts.room;
		cmd.finalize = (state_q == S_FINAL) && sts.out_free;
	end

	always_comb begin
		state_d    = state_q;
		from_ram_d = from_ram_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					state_d    = S_FEED;
					from_ram_d = 1'b0;
				end
			end
			S_FEED: begin
				if (cmd.feed) begin
					if (sts.full_next) begin
						state_d = S_FIN;
					end else if (sts.more_next) begin
						state_d = S_READ;
					end else if (sts.end_doc && sts.open_next) begin
						state_d = S_FIN;
					end else if (sts.end_doc) begin
						state_d = S_FINAL;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_READ: begin
				state_d    = S_FEED;
				from_ram_d = 1'b1;
			end
			S_FIN: begin
				if (cmd.fin_dec) begin
					if (sts.more_next) begin
						state_d = S_READ;
					end else if (sts.end_doc) begin
						state_d = S_FINAL;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FINAL: begin
				if (cmd.finalize) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			from_ram_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			from_ram_q <= from_ram_d;
		end
	end

	`HWM_ASSERT_NEXT(a_accept_feeds, cmd.accept, state_q == S_FEED && !from_ram_q, "accept must lead to a feed of the input byte")
	`HWM_ASSERT_IMPL(a_final_is_end, state_q == S_FINAL, sts.end_doc, "flush entered without end of document")
	`HWM_ASSERT_IMPL(a_one_action, 1'b1, $onehot0({cmd.accept, cmd.feed, cmd.rd_issue, cmd.fin_dec, cmd.finalize}), "more than one datapath action in a cycle")
endmodule

// ===== design/hwm_datapath.sv =====
// Datapath: byte stream RAM, lookahead window recognizer, parse state and output stage.
// Depends on hwm_pkg, hwm_ram and the assertion macro header.
`include "html_whitespace_minifier_macros.svh"
module hwm_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  hwm_pkg::dp_cmd_t cmd,
	output hwm_pkg::dp_sts_t sts,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             out_bvalid,
	output logic             out_last,
	output logic             out_ovf
);
	import hwm_pkg::*;

	// stream pointers: window starts at q, next byte to feed at rd, next free at wr
	ptr_t       wr_q, rd_q, q_q, nx_wr, nx_rd, nx_q;
	cnt_t       cnt_q, nx_cnt;
	logic [1:0] mode_q, nx_mode, tagid_q, nx_tag, dash_q, nx_dash;
	logic       started_q, nx_started, lastsp_q, nx_lastsp;
	logic [2:0] ph_q, nx_ph;
	logic [3:0] cand_q, nx_cand, k_q, nx_k;
	logic       slash_q, nx_slash;
	logic [7:0] cur_q;
	logic       end_q, ovf_q;
	logic       hold_v_q, hold_ovf_q;
	logic [7:0] hold_byte_q;
	logic       out_v_q, out_bv_q, out_last_q, out_ovf_q;
	logic [7:0] out_byte_q;

	logic [7:0] ram_rdata, b_cur;
	logic       win_open, verb;
	logic [3:0] name_k, ns_more, ns_match;
	logic [1:0] m_tag, f_tag, dec_tag;
	logic       f_hit;
	logic [2:0] nm_dec, nm_ph, fin_code, dec;
	logic       emit, out_free, full_next;
	logic [7:0] emit_byte;

	hwm_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (wr_q),
		.wdata (in_byte),
		.re    (cmd.rd_issue),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	assign b_cur    = cmd.from_ram ? ram_rdata : cur_q;
	assign win_open = (cnt_q != '0);
	assign verb     = (mode_q == MODE_VERBATIM);
	assign name_k   = (ph_q == PH_NAME) ? k_q : 4'd0;

	// one name-matching step per candidate tag
	always_comb begin
		ns_more  = '0;
		ns_match = '0;
		m_tag    = TAG_PRE;
		f_hit    = 1'b0;
		f_tag    = TAG_PRE;
		for (int t = 0; t < 4; t++) begin
			if (cand_q[t]) begin
				if (name_k < tag_len(2'(t))) begin
					ns_more[t] = (low_case(b_cur) == tag_char(2'(t), name_k[2:0]));
				end else if (name_k == tag_len(2'(t))) begin
					ns_match[t] = is_delim(b_cur);
				end
				if (k_q == tag_len(2'(t))) begin
					f_hit = 1'b1;
					f_tag = 2'(t);
				end
			end
			if (ns_match[t]) begin
				m_tag = 2'(t);
			end
		end
	end

	always_comb begin
		if (ns_match != '0) begin
			if (verb) begin
				nm_dec = DEC_CLOSE;
				nm_ph  = ph_q;
			end else if (b_cur == CH_GT) begin
				nm_dec = DEC_OPEN;
				nm_ph  = ph_q;
			end else begin
				nm_dec = DEC_PEND;
				nm_ph  = PH_GT;
			end
		end else if (ns_more != '0) begin
			nm_dec = DEC_PEND;
			nm_ph  = PH_NAME;
		end else begin
			nm_dec = DEC_PLAIN;
			nm_ph  = ph_q;
		end
	end

	// decision when no more bytes will come (end of document or full window)
	always_comb begin
		case (ph_q)
			PH_NAME: fin_code = f_hit ? (verb ? DEC_CLOSE : DEC_OPEN) : DEC_PLAIN;
			PH_GT:   fin_code = DEC_OPEN;
			default: fin_code = DEC_PLAIN;
		endcase
	end

	always_comb begin
		nx_wr      = wr_q;
		nx_rd      = rd_q;
		nx_q       = q_q;
		nx_cnt     = cnt_q;
		nx_mode    = mode_q;
		nx_tag     = tagid_q;
		nx_dash    = dash_q;
		nx_started = started_q;
		nx_lastsp  = lastsp_q;
		nx_ph      = ph_q;
		nx_cand    = cand_q;
		nx_k       = k_q;
		nx_slash   = slash_q;
		dec        = DEC_PEND;
		dec_tag    = tagid_q;
		emit       = 1'b0;
		emit_byte  = b_cur;

		if (cmd.accept) begin
			nx_wr = wr_q + ptr_t'(1);
		end

		if (cmd.feed) begin
			nx_rd = rd_q + ptr_t'(1);
			if (win_open) begin
				nx_cnt = cnt_q + cnt_t'(1);
				case (ph_q)
					PH_LT: begin
						if (verb) begin
							if (b_cur == CH_SLASH) nx_ph = PH_WS;
							else dec = DEC_PLAIN;
						end else if (b_cur == CH_SLASH) begin
							dec = DEC_PLAIN;
						end else if (b_cur == CH_BANG) begin
							nx_ph = PH_BANG1;
						end else if (is_ws(b_cur)) begin
							nx_ph = PH_WS;
						end else begin
							dec      = nm_dec;
							nx_ph    = nm_ph;
							dec_tag  = m_tag;
							nx_cand  = ns_more;
							nx_k     = name_k + 4'd1;
							nx_slash = (b_cur == CH_SLASH);
							if (nm_ph == PH_GT) nx_tag = m_tag;
						end
					end
					PH_WS, PH_NAME: begin
						if (ph_q == PH_WS && is_ws(b_cur)) begin
							nx_ph = PH_WS;
						end else begin
							dec      = nm_dec;
							nx_ph    = nm_ph;
							dec_tag  = m_tag;
							nx_cand  = ns_more;
							nx_k     = name_k + 4'd1;
							nx_slash = (b_cur == CH_SLASH);
							// normal mode only: the tag id register holds the matched name
							if (nm_ph == PH_GT) nx_tag = m_tag;
						end
					end
					PH_BANG1: begin
						if (b_cur == CH_DASH) nx_ph = PH_BANG2;
						else dec = DEC_PLAIN;
					end
					PH_BANG2: begin
						dec = (b_cur == CH_DASH) ? DEC_COMMENT : DEC_PLAIN;
					end
					PH_GT: begin
						if (b_cur == CH_GT) dec = slash_q ? DEC_PLAIN : DEC_OPEN;
						else nx_slash = (b_cur == CH_SLASH);
					end
					default: dec = DEC_PLAIN;
				endcase
			end else if (mode_q == MODE_COMMENT) begin
				if (b_cur == CH_GT && dash_q == 2'd2) begin
					nx_mode = MODE_NORMAL;
				end else if (b_cur == CH_DASH) begin
					if (dash_q != 2'd2) nx_dash = dash_q + 2'd1;
				end else begin
					nx_dash = 2'd0;
				end
			end else if (b_cur == CH_LT) begin
				nx_cnt  = cnt_t'(1);
				nx_q    = rd_q;
				nx_ph   = PH_LT;
				nx_cand = verb ? (4'b0001 << tagid_q) : 4'b1111;
				nx_k    = 4'd0;
			end else if (verb) begin
				emit = 1'b1;
			end else if (is_ws(b_cur)) begin
				emit      = started_q && !lastsp_q;
				emit_byte = CH_SPACE;
			end else begin
				emit = 1'b1;
			end
		end

		if (cmd.fin_dec) begin
			dec     = fin_code;
			dec_tag = (ph_q == PH_NAME) ? f_tag : tagid_q;
		end

		if (dec != DEC_PEND) begin
			nx_cnt = '0;
			if (dec == DEC_COMMENT) begin
				nx_mode = MODE_COMMENT;
				nx_dash = 2'd0;
				nx_rd   = q_q + ptr_t'(4);
			end else begin
				emit      = 1'b1;
				emit_byte = CH_LT;
				nx_rd     = q_q + ptr_t'(1);
				if (dec == DEC_OPEN) begin
					nx_mode = MODE_VERBATIM;
					nx_tag  = dec_tag;
				end else if (dec == DEC_CLOSE) begin
					nx_mode = MODE_NORMAL;
				end
			end
		end

		if (emit) begin
			nx_started = 1'b1;
			nx_lastsp  = (emit_byte == CH_SPACE);
		end

		if (cmd.finalize) begin
			nx_mode    = MODE_NORMAL;
			nx_tag     = TAG_PRE;
			nx_cnt     = '0;
			nx_dash    = 2'd0;
			nx_started = 1'b0;
			nx_lastsp  = 1'b0;
		end
	end

	assign full_next = cmd.feed && win_open && (dec == DEC_PEND)
		&& (nx_cnt == cnt_t'(LOOKAHEAD_DEPTH));
	assign out_free  = !out_v_q || out_ready;

	always_comb begin
		sts           = '0;
		sts.out_free  = out_free;
		sts.room      = end_q ? (!hold_v_q || out_free) : out_free;
		sts.end_doc   = end_q;
		sts.full_next = full_next;
		sts.more_next = (nx_rd != wr_q);
		sts.open_next = (nx_cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rd_q      <= '0;
			q_q       <= '0;
			cnt_q     <= '0;
			mode_q    <= MODE_NORMAL;
			tagid_q   <= TAG_PRE;
			dash_q    <= 2'd0;
			started_q <= 1'b0;
			lastsp_q  <= 1'b0;
			ph_q      <= PH_LT;
			cand_q    <= '0;
			k_q       <= '0;
			slash_q   <= 1'b0;
			end_q     <= 1'b0;
			ovf_q     <= 1'b0;
			hold_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			wr_q      <= nx_wr;
			rd_q      <= nx_rd;
			q_q       <= nx_q;
			cnt_q     <= nx_cnt;
			mode_q    <= nx_mode;
			tagid_q   <= nx_tag;
			dash_q    <= nx_dash;
			started_q <= nx_started;
			lastsp_q  <= nx_lastsp;
			ph_q      <= nx_ph;
			cand_q    <= nx_cand;
			k_q       <= nx_k;
			slash_q   <= nx_slash;
			if (cmd.accept) begin
				end_q <= in_last;
				ovf_q <= 1'b0;
			end else if (full_next) begin
				ovf_q <= 1'b1;
			end

			// output stage valid and end-of-document hold slot
			if (cmd.finalize) begin
				out_v_q  <= 1'b1;
				hold_v_q <= 1'b0;
			end else if (emit && (!end_q || hold_v_q)) begin
				out_v_q <= 1'b1;
			end else begin
				if (out_v_q && out_ready) begin
					out_v_q <= 1'b0;
				end
				if (emit) begin
					hold_v_q <= 1'b1;
				end
			end
		end
	end

	// payload: output stage and end-of-document hold slot
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q <= in_byte;
		end
		if (emit) begin
			if (!end_q) begin
				out_byte_q <= emit_byte;
				out_bv_q   <= 1'b1;
				out_last_q <= 1'b0;
				out_ovf_q  <= ovf_q;
			end else begin
				if (hold_v_q) begin
					out_byte_q <= hold_byte_q;
					out_bv_q   <= 1'b1;
					out_last_q <= 1'b0;
					out_ovf_q  <= hold_ovf_q;
				end
				hold_byte_q <= emit_byte;
				hold_ovf_q  <= ovf_q;
			end
		end
		if (cmd.finalize) begin
			out_byte_q <= hold_v_q ? hold_byte_q : 8'h00;
			out_bv_q   <= hold_v_q;
			out_last_q <= 1'b1;
			out_ovf_q  <= hold_v_q ? hold_ovf_q : ovf_q;
		end
	end

	assign out_valid  = out_v_q;
	assign out_byte   = out_byte_q;
	assign out_bvalid = out_bv_q;
	assign out_last   = out_last_q;
	assign out_ovf    = out_ovf_q;

	`HWM_ASSERT_IMPL(a_hold_in_end, hold_v_q, end_q, "hold slot used outside a final item")
	`HWM_ASSERT_IMPL(a_marker_clean, out_v_q && !out_bv_q, out_byte_q == 8'h00 && out_last_q, "end marker must be zero and last")
	`HWM_ASSERT_IMPL(a_window_bound, 1'b1, cnt_q <= cnt_t'(LOOKAHEAD_DEPTH), "window count beyond depth")
endmodule

// ===== tb/tb_html_whitespace_minifier.sv =====
// Self-checking testbench for html_whitespace_minifier: documents stream in as
// bytes, a built-in minifier predictor queues the expected output items.
// Depends on hwm_pkg and the minifier RTL.
module tb_html_whitespace_minifier;
	timeunit 1ns;
	timeprecision 1ps;
	import hwm_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       drain;     // wait for every expected item before sending
	} doc_byte_t;

	typedef struct {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
		logic       overflow;
	} min_out_t;

	localparam int WIN_MAX = LOOKAHEAD_DEPTH;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	html_whitespace_minifier dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	doc_byte_t doc_bytes[$];       // bytes still to be sent
	min_out_t  minified[$];        // output items still owed by the block
	int        total_bytes;
	int        sent_bytes = 0;
	int        errors = 0;

	// ---------------------------------------------------------------------
	// Predictor state: one copy of the parser, mirrored byte for byte.
	// ---------------------------------------------------------------------
	logic [1:0] mode;
	logic [1:0] raw_tag;
	logic [7:0] win[WIN_MAX];
	int         win_n;
	int         dashes;
	bit         started;
	bit         last_space;
	bit         step_ovf;
	logic [7:0] replay[$];
	min_out_t   step_out[$];

	function automatic bit white(logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic bit delim(logic [7:0] b);
		return b == CH_GT || b == CH_SPACE || b == 8'h09 || b == 8'h0A ||
			b == 8'h0D || b == CH_SLASH;
	endfunction

	function automatic logic [7:0] lower(logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic string raw_name(logic [1:0] t);
		case (t)
			TAG_PRE:      return "pre";
			TAG_SCRIPT:   return "script";
			TAG_STYLE:    return "style";
			default:      return "textarea";
		endcase
	endfunction

	task automatic reset_parser();
		mode = MODE_NORMAL;
		raw_tag = TAG_PRE;
		win_n = 0;
		dashes = 0;
		started = 0;
		last_space = 0;
		replay.delete();
	endtask

	task automatic emit(logic [7:0] b, bit valid);
		min_out_t r;
		r.out_byte = b;
		r.byte_valid = valid;
		r.out_last = 0;
		r.overflow = 0;
		step_out.insert(step_out.size(), r);
		if (valid) begin
			started = 1;
			last_space = (b == CH_SPACE);
		end
	endtask

	// 0 no match, 1 needs more bytes, 2 match
	function automatic int name_at(int j, logic [1:0] t, bit fin);
		string s;
		s = raw_name(t);
		for (int k = 0; k < s.len(); k++) begin
			if (j + k >= win_n) return fin ? 0 : 1;
			if (lower(win[j + k]) != s[k]) return 0;
		end
		if (j + s.len() >= win_n) return fin ? 2 : 1;
		return delim(win[j + s.len()]) ? 2 : 0;
	endfunction

	function automatic logic [2:0] classify(bit fin, output logic [1:0] tag);
		int j;
		int s;
		int found;
		bit pend;
		tag = TAG_PRE;
		found = 4;
		pend = 0;
		if (win_n < 2) return fin ? DEC_PLAIN : DEC_PEND;
		if (mode == MODE_VERBATIM) begin
			if (win[1] != CH_SLASH) return DEC_PLAIN;
			j = 2;
			while (j < win_n && white(win[j])) j++;
			s = name_at(j, raw_tag, fin);
			return s == 2 ? DEC_CLOSE : (s == 1 ? DEC_PEND : DEC_PLAIN);
		end
		if (win[1] == CH_SLASH) return DEC_PLAIN;
		if (win[1] == CH_BANG) begin
			// "<!" only turns into a comment once both dashes are in
			if ((win_n < 3 || win[2] == CH_DASH) && (win_n < 4 || win[3] == CH_DASH)) begin
				if (win_n >= 4) return DEC_COMMENT;
				if (!fin) return DEC_PEND;
			end
			return DEC_PLAIN;
		end
		j = 1;
		while (j < win_n && white(win[j])) j++;
		for (int t = 0; t < 4; t++) begin
			s = name_at(j, t[1:0], fin);
			if (s == 2) begin
				found = t;
				break;
			end
			if (s == 1) pend = 1;
		end
		if (found == 4) return pend ? DEC_PEND : DEC_PLAIN;
		tag = found[1:0];
		// a self-closing tag stays in normal mode
		for (int p = j; p < win_n; p++)
			if (win[p] == CH_GT) return (win[p - 1] == CH_SLASH) ? DEC_PLAIN : DEC_OPEN;
		return fin ? DEC_OPEN : DEC_PEND;
	endfunction

	task automatic resolve(logic [2:0] code, logic [1:0] tag);
		logic [7:0] tmp[$];
		int start;
		start = 1;
		if (code == DEC_COMMENT) begin
			mode = MODE_COMMENT;
			dashes = 0;
			start = 4;
		end else begin
			emit(CH_LT, 1);
			if (code == DEC_OPEN) begin
				mode = MODE_VERBATIM;
				raw_tag = tag;
			end else if (code == DEC_CLOSE) begin
				mode = MODE_NORMAL;
			end
		end
		// window tail goes back through the parser ahead of what was queued
		for (int i = start; i < win_n; i++) tmp.insert(tmp.size(), win[i]);
		foreach (replay[i]) if (tmp.size() < WIN_MAX) tmp.insert(tmp.size(), replay[i]);
		win_n = 0;
		replay = tmp;
	endtask

	task automatic parse_byte(logic [7:0] b);
		logic [2:0] code;
		logic [1:0] tag;
		if (win_n > 0) begin
			if (win_n < WIN_MAX) begin
				win[win_n] = b;
				win_n++;
			end
			code = classify(0, tag);
			if (code == DEC_PEND && win_n >= WIN_MAX) begin
				code = classify(1, tag);
				step_ovf = 1;
			end
			if (code != DEC_PEND) resolve(code, tag);
		end else if (mode == MODE_COMMENT) begin
			if (b == CH_GT && dashes >= 2) mode = MODE_NORMAL;
			else if (b == CH_DASH) begin
				if (dashes < 2) dashes++;
			end else dashes = 0;
		end else if (b == CH_LT) begin
			win[0] = b;
			win_n = 1;
		end else if (mode == MODE_VERBATIM) begin
			emit(b, 1);
		end else if (white(b)) begin
			if (started && !last_space) emit(CH_SPACE, 1);
		end else begin
			emit(b, 1);
		end
	endtask

	task automatic predict_byte(logic [7:0] b, bit eod);
		logic [2:0] code;
		logic [1:0] tag;
		step_out.delete();
		step_ovf = 0;
		replay = '{b};
		forever begin
			while (replay.size() > 0) parse_byte(replay.pop_front());
			if (!eod || win_n == 0) break;
			// end of document forces whatever is pending
			code = classify(1, tag);
			if (code == DEC_PEND) code = DEC_PLAIN;
			resolve(code, tag);
		end
		if (eod) begin
			if (step_out.size() == 0) emit(8'h00, 0);
			step_out[step_out.size() - 1].out_last = 1;
			reset_parser();
		end
		foreach (step_out[k]) begin
			step_out[k].overflow = step_ovf;
			minified.insert(minified.size(), step_out[k]);
		end
	endtask

	// ---------------------------------------------------------------------
	// Document builders
	// ---------------------------------------------------------------------
	task automatic put(logic [7:0] b);
		doc_byte_t d;
		d.data = b;
		d.last = 0;
		d.drain = 0;
		doc_bytes.insert(doc_bytes.size(), d);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endtask

	task automatic end_doc();
		doc_bytes[doc_bytes.size() - 1].last = 1;
	endtask

	task automatic put_name(logic [1:0] t);
		string s;
		s = raw_name(t);
		for (int i = 0; i < s.len(); i++)
			put(($urandom_range(1) != 0) ? s[i] - 8'd32 : s[i]);
	endtask

	task automatic put_ws(int n);
		logic [7:0] ws_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		for (int i = 0; i < n; i++) put(ws_set[$urandom_range(5)]);
	endtask

	task automatic random_doc();
		int n_tok;
		logic [1:0] t;
		n_tok = $urandom_range(10, 3);
		for (int k = 0; k < n_tok; k++) begin
			t = 2'($urandom_range(3));
			case ($urandom_range(9))
				0, 1: for (int i = $urandom_range(6, 1); i > 0; i--)
					put(8'($urandom_range("z", "a")));
				2:    put_ws($urandom_range(4, 1));
				3, 4: begin
					// opening raw-content tag, sometimes self-closing or broken
					put(CH_LT);
					if ($urandom_range(3) == 0) put_ws($urandom_range(2, 1));
					put_name(t);
					case ($urandom_range(4))
						0: put(CH_GT);
						1: put_text(" a=1>");
						2: put_text("/>");
						3: put(CH_SPACE);
						default: put(8'($urandom_range(255)));
					endcase
					put_text(" x  y ");
					if ($urandom_range(3) != 0) begin
						put_text("</");
						if ($urandom_range(3) == 0) put_ws(1);
						put_name($urandom_range(4) == 0 ? 2'($urandom_range(3)) : t);
						put(CH_GT);
					end
				end
				5: begin
					put_text("</");
					put_name(t);
					put(CH_GT);
				end
				6: begin
					put_text("<!--");
					for (int i = $urandom_range(4); i > 0; i--)
						put($urandom_range(2) == 0 ? CH_DASH : 8'($urandom_range("z", "a")));
					if ($urandom_range(4) != 0) put_text("-->");
				end
				7: begin
					put(CH_LT);
					put(8'($urandom_range(255)));
				end
				default: put(8'($urandom_range(255)));
			endcase
		end
		end_doc();
	endtask

	// ---------------------------------------------------------------------
	// Sender: one item per handshake, idling per phase of the run.
	// ---------------------------------------------------------------------
	int send_idle;
	int recv_idle;

	always @(posedge clk or negedge arst_n) begin
		bit         go;
		logic       nxt_valid;
		logic [7:0] nxt_data;
		logic       nxt_last;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tlast  <= 1'b0;
		end else begin
			nxt_valid = s_axis_tvalid;
			nxt_data  = s_axis_tdata;
			nxt_last  = s_axis_tlast;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_byte(s_axis_tdata, s_axis_tlast);
				sent_bytes++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && doc_bytes.size() > 0) begin
				go = $urandom_range(99) >= send_idle;
				// drain marker: hold off until the block has caught up
				if (doc_bytes[0].drain && minified.size() > 0) go = 0;
				if (go) begin
					nxt_valid = 1'b1;
					nxt_data  = doc_bytes[0].data;
					nxt_last  = doc_bytes[0].last;
					void'(doc_bytes.pop_front());
				end
			end
			s_axis_tvalid <= nxt_valid;
			s_axis_tdata  <= nxt_data;
			s_axis_tlast  <= nxt_last;
		end
	end

	// idle rates follow the fraction of bytes already sent
	always_comb begin
		if (sent_bytes < total_bytes / 3) begin
			send_idle = 36;
			recv_idle = 88;
		end else if (sent_bytes < 2 * total_bytes / 3) begin
			send_idle = 88;
			recv_idle = 36;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: random backpressure, each item checked against the oldest
	// expectation.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		min_out_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (minified.size() == 0) begin
					$display("%0t: unexpected item tdata=%02h tuser=%b tlast=%b",
						$realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					want = minified.pop_front();
					if (m_axis_tdata !== want.out_byte || m_axis_tuser[0] !== want.byte_valid ||
						m_axis_tuser[1] !== want.overflow || m_axis_tlast !== want.out_last) begin
						$display("%0t: mismatch expected byte=%02h valid=%b ovf=%b last=%b, got byte=%02h valid=%b ovf=%b last=%b",
							$realtime, want.out_byte, want.byte_valid, want.overflow,
							want.out_last, m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1],
							m_axis_tlast);
						errors++;
					end
				end
			end
			m_axis_tready <= $urandom_range(99) >= recv_idle;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------------
	initial begin
		reset_parser();
		// directed documents
		put_text("  Hi \t\n x ");
		end_doc();
		put(8'hFF);
		put(8'h00);
		put_text("<!-- c -->y<!-->z");
		end_doc();
		put_text("<PRE >a  b</ pre >c  d");
		end_doc();
		put_text("<script/> e  <!--");
		end_doc();
		put_text("< style>p  q");
		end_doc();
		put_text("<textarea");
		end_doc();
		// whitespace after '<' fills the window before a name shows up
		put(CH_LT);
		put_ws(34);
		end_doc();
		// 'pre' run straight into letters is no tag match, so the '<' is plain text
		put_text("<pre");
		for (int i = 0; i < 30; i++) put("a");
		put_text(" k");
		end_doc();
		put(CH_LT);
		end_doc();
		// block must be idle before the byte halfway through these documents is sent
		doc_bytes[doc_bytes.size() / 2].drain = 1;
		while (doc_bytes.size() < 280) random_doc();
		doc_bytes[doc_bytes.size() - 40].drain = 1;
		total_bytes = doc_bytes.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (doc_bytes.size() == 0 && !s_axis_tvalid && minified.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && minified.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
